@@ rtl/tcpwc_pkg.sv @@
// Shared constants, codes and types for the TCP window and close engine.
package tcpwc_pkg;

    localparam int RECV_WINDOW = 3072;
    localparam int MAX_PAYLOAD = 536;
    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // request selector
    localparam logic [1:0] FUNC_SEND  = 2'd0;
    localparam logic [1:0] FUNC_SEG   = 2'd1;
    localparam logic [1:0] FUNC_CLOSE = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_STATUS  = 3'd0;
    localparam logic [2:0] KIND_DATA    = 3'd1;
    localparam logic [2:0] KIND_ACK     = 3'd2;
    localparam logic [2:0] KIND_FIN     = 3'd3;
    localparam logic [2:0] KIND_DELIVER = 3'd4;

    // connection close states
    localparam logic [2:0] CS_ESTABLISHED = 3'd0;
    localparam logic [2:0] CS_FIN_WAIT_1  = 3'd1;
    localparam logic [2:0] CS_FIN_WAIT_2  = 3'd2;
    localparam logic [2:0] CS_CLOSE_WAIT  = 3'd3;
    localparam logic [2:0] CS_LAST_ACK    = 3'd4;
    localparam logic [2:0] CS_CLOSING     = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_SEND_WINDOW = 2'd0;
    localparam logic [1:0] REG_LOCAL_SEQ   = 2'd1;
    localparam logic [1:0] REG_REMOTE_SEQ  = 2'd2;

    // one table entry: start and length
    typedef struct packed {
        logic [31:0] seq;
        logic [9:0]  len;
    } entry_t;

endpackage

@@ rtl/tcp_window_and_close_engine_core.sv @@
// Top level: sequenced window, retire, reassembly and close engine.
// A send passes through ST_SEND; a close, FIN or status result goes straight to ST_LAST; an ACK
// runs a min search over the in-flight table plus a check per retired entry; data runs the
// window test, a table scan, a store and a delivery scan that restarts after each delivery.
// One item at a time; s_tready is high only while the sequencer is idle.
// aresetn (synchronous, active low) clears control state and both tables' valid bits.
module tcp_window_and_close_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // seg_seq[31:0], seg_ack[63:32], seg_len[73:64], seg_fin[74],
    // seg_ackflag[75], app_avail[91:76], zero pad
    input  logic [95:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_seq[31:0], out_ack[63:32], out_len[73:64], conn_state[76:74],
    // closed[77], dropped[78], zero pad
    output logic [79:0] m_tdata,
    // kind[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IW = tcpwc_pkg::IDX_W;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SEND  = 9'b000000010,
        ST_RMIN  = 9'b000000100,
        ST_RCHK  = 9'b000001000,
        ST_DCLS  = 9'b000010000,
        ST_DSCAN = 9'b000100000,
        ST_DSTOR = 9'b001000000,
        ST_DDLV  = 9'b010000000,
        ST_LAST  = 9'b100000000
    } state_t;

    state_t state_reg;

    // configuration and connection state
    logic [11:0] send_window_reg;
    logic [31:0] send_next_reg, send_unacked_reg, recv_next_reg;
    logic [2:0]  close_state_reg;
    logic        finished_reg, dropped_reg;

    // tables
    logic              fl_valid_reg [tcpwc_pkg::TABLE_DEPTH];
    tcpwc_pkg::entry_t fl_reg       [tcpwc_pkg::TABLE_DEPTH];
    logic              ra_valid_reg [tcpwc_pkg::TABLE_DEPTH];
    tcpwc_pkg::entry_t ra_reg       [tcpwc_pkg::TABLE_DEPTH];

    // latched item
    logic [31:0] seg_seq_reg, seg_ack_reg;
    logic [9:0]  seg_len_reg;
    logic [15:0] app_avail_reg;

    // sequencer working registers
    logic [IW-1:0] idx_reg, best_reg, slot_reg;
    logic          best_found_reg, slot_found_reg, dup_reg;
    logic [31:0]   best_off_reg;
    logic [31:0]   st_seq_reg;
    logic [9:0]    st_len_reg;
    logic [2:0]    pend_kind_reg;
    logic [31:0]   pend_seq_reg;
    logic [9:0]    pend_len_reg;

    // output register
    logic        m_valid_reg, m_last_reg;
    logic [2:0]  m_kind_reg;
    logic [31:0] m_seq_reg, m_ack_reg;
    logic [9:0]  m_len_reg;
    logic [2:0]  m_cs_reg;
    logic        m_closed_reg, m_drop_reg;

    logic accept, can_emit;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign can_emit  = !m_valid_reg || m_tready;

    // input unpack
    logic [31:0] in_seq, in_ack;
    logic [9:0]  in_len;
    logic        in_fin, in_ackflag;
    logic [15:0] in_avail;
    assign in_seq     = s_tdata[31:0];
    assign in_ack     = s_tdata[63:32];
    assign in_len     = s_tdata[73:64];
    assign in_fin     = s_tdata[74];
    assign in_ackflag = s_tdata[75];
    assign in_avail   = s_tdata[91:76];

    // send length: offered bytes capped by payload size and free window
    logic [31:0] inflight;
    logic [11:0] free_win;
    logic [15:0] n_cap;
    logic [9:0]  send_len;
    always_comb begin
        inflight = send_next_reg - send_unacked_reg;
        free_win = (inflight >= {20'd0, send_window_reg}) ? 12'd0
                 : send_window_reg - inflight[11:0];
        n_cap = (app_avail_reg > 16'(tcpwc_pkg::MAX_PAYLOAD))
              ? 16'(tcpwc_pkg::MAX_PAYLOAD) : app_avail_reg;
        if (n_cap > {4'd0, free_win}) begin
            n_cap = {4'd0, free_win};
        end
        send_len = n_cap[9:0];
    end

    // first free in-flight slot
    logic          fl_free_found;
    logic [IW-1:0] fl_free_idx;
    always_comb begin
        fl_free_found = 1'b0;
        fl_free_idx   = '0;
        for (int i = tcpwc_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!fl_valid_reg[i]) begin
                fl_free_found = 1'b1;
                fl_free_idx   = IW'(i);
            end
        end
    end

    // shared compare path for the in-flight table search and retire check
    logic [31:0] fl_off, fl_end, ack_off, end_off;
    assign fl_off  = fl_reg[idx_reg].seq - send_unacked_reg;
    assign fl_end  = fl_reg[best_reg].seq + {22'd0, fl_reg[best_reg].len};
    assign ack_off = seg_ack_reg - send_unacked_reg;
    assign end_off = fl_end - send_unacked_reg;

    // receive window classification
    logic signed [32:0] d_s, dl_s;
    logic               out_win;
    always_comb begin
        d_s     = 33'(signed'(seg_seq_reg - recv_next_reg));
        dl_s    = d_s + 33'(signed'({1'b0, seg_len_reg}));
        out_win = (d_s >= 33'(tcpwc_pkg::RECV_WINDOW)) || (dl_s <= 33'sd0);
    end

    logic last_idx;
    assign last_idx = (idx_reg == IW'(tcpwc_pkg::TABLE_DEPTH - 1));

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            send_window_reg  <= 12'(tcpwc_pkg::RECV_WINDOW);
            send_next_reg    <= 32'd1;
            send_unacked_reg <= 32'd1;
            recv_next_reg    <= 32'd1;
            close_state_reg  <= tcpwc_pkg::CS_ESTABLISHED;
            finished_reg     <= 1'b0;
            dropped_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
            for (int i = 0; i < tcpwc_pkg::TABLE_DEPTH; i++) begin
                fl_valid_reg[i] <= 1'b0;
                ra_valid_reg[i] <= 1'b0;
            end
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            // configuration writes
            if (cfg_valid) begin
                case (cfg_index)
                    tcpwc_pkg::REG_SEND_WINDOW: send_window_reg <= cfg_data[11:0];
                    tcpwc_pkg::REG_LOCAL_SEQ: begin
                        send_next_reg    <= cfg_data;
                        send_unacked_reg <= cfg_data;
                    end
                    tcpwc_pkg::REG_REMOTE_SEQ: recv_next_reg <= cfg_data;
                    default: ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        seg_seq_reg    <= in_seq;
                        seg_ack_reg    <= in_ack;
                        seg_len_reg    <= in_len;
                        app_avail_reg  <= in_avail;
                        dropped_reg    <= 1'b0;
                        pend_kind_reg  <= tcpwc_pkg::KIND_STATUS;
                        pend_seq_reg   <= send_next_reg;
                        pend_len_reg   <= '0;
                        idx_reg        <= '0;
                        best_found_reg <= 1'b0;
                        slot_found_reg <= 1'b0;
                        dup_reg        <= 1'b0;
                        state_reg      <= ST_LAST;
                        if (!finished_reg) begin
                            case (s_tuser)
                                tcpwc_pkg::FUNC_SEND: state_reg <= ST_SEND;
                                tcpwc_pkg::FUNC_SEG: begin
                                    if (in_fin) begin
                                        case (close_state_reg)
                                            tcpwc_pkg::CS_FIN_WAIT_1: begin
                                                pend_kind_reg   <= tcpwc_pkg::KIND_ACK;
                                                close_state_reg <= tcpwc_pkg::CS_CLOSING;
                                            end
                                            tcpwc_pkg::CS_FIN_WAIT_2: begin
                                                pend_kind_reg <= tcpwc_pkg::KIND_ACK;
                                                finished_reg  <= 1'b1;
                                            end
                                            tcpwc_pkg::CS_ESTABLISHED: begin
                                                pend_kind_reg   <= tcpwc_pkg::KIND_ACK;
                                                close_state_reg <= tcpwc_pkg::CS_CLOSE_WAIT;
                                            end
                                            default: ;
                                        endcase
                                    end else if (in_ackflag) begin
                                        if (close_state_reg == tcpwc_pkg::CS_FIN_WAIT_1) begin
                                            close_state_reg <= tcpwc_pkg::CS_FIN_WAIT_2;
                                        end else if (close_state_reg == tcpwc_pkg::CS_CLOSING
                                                  || close_state_reg == tcpwc_pkg::CS_LAST_ACK) begin
                                            finished_reg <= 1'b1;
                                        end
                                        // ack outside unacked..next retires nothing
                                        if ((in_ack - send_unacked_reg)
                                            <= (send_next_reg - send_unacked_reg)) begin
                                            state_reg <= ST_RMIN;
                                        end
                                    end else if (in_len != 10'd0) begin
                                        state_reg <= ST_DCLS;
                                    end
                                end
                                tcpwc_pkg::FUNC_CLOSE: begin
                                    if (close_state_reg == tcpwc_pkg::CS_ESTABLISHED) begin
                                        pend_kind_reg   <= tcpwc_pkg::KIND_FIN;
                                        close_state_reg <= tcpwc_pkg::CS_FIN_WAIT_1;
                                    end else if (close_state_reg == tcpwc_pkg::CS_CLOSE_WAIT) begin
                                        pend_kind_reg   <= tcpwc_pkg::KIND_FIN;
                                        close_state_reg <= tcpwc_pkg::CS_LAST_ACK;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end

                // record and emit a data header
                ST_SEND: begin
                    if (send_len != 10'd0) begin
                        if (!fl_free_found) begin
                            dropped_reg <= 1'b1;
                        end else begin
                            fl_valid_reg[fl_free_idx] <= 1'b1;
                            fl_reg[fl_free_idx].seq   <= send_next_reg;
                            fl_reg[fl_free_idx].len   <= send_len;
                            pend_kind_reg             <= tcpwc_pkg::KIND_DATA;
                            pend_len_reg              <= send_len;
                            send_next_reg             <= send_next_reg + {22'd0, send_len};
                        end
                    end
                    state_reg <= ST_LAST;
                end

                // find the oldest in-flight entry
                ST_RMIN: begin
                    if (fl_valid_reg[idx_reg]
                        && (!best_found_reg || fl_off < best_off_reg)) begin
                        best_found_reg <= 1'b1;
                        best_reg       <= idx_reg;
                        best_off_reg   <= fl_off;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (last_idx) begin
                        state_reg <= ST_RCHK;
                    end
                end

                // retire it if fully acknowledged, then search again
                ST_RCHK: begin
                    idx_reg        <= '0;
                    best_found_reg <= 1'b0;
                    if (!best_found_reg || end_off > ack_off) begin
                        state_reg <= ST_LAST;
                    end else begin
                        send_unacked_reg       <= fl_end;
                        fl_valid_reg[best_reg] <= 1'b0;
                        state_reg              <= ST_RMIN;
                    end
                end

                // window test and trim
                ST_DCLS: begin
                    pend_kind_reg <= tcpwc_pkg::KIND_ACK;
                    if (out_win) begin
                        state_reg <= ST_LAST;
                    end else begin
                        if (d_s < 33'sd0) begin
                            st_seq_reg <= recv_next_reg;
                            st_len_reg <= dl_s[9:0];
                        end else begin
                            st_seq_reg <= seg_seq_reg;
                            st_len_reg <= (dl_s <= 33'(tcpwc_pkg::RECV_WINDOW)) ? seg_len_reg
                                        : 10'(33'(tcpwc_pkg::RECV_WINDOW) - d_s);
                        end
                        state_reg <= ST_DSCAN;
                    end
                end

                // duplicate check and free slot search
                ST_DSCAN: begin
                    if (ra_valid_reg[idx_reg] && ra_reg[idx_reg].seq == st_seq_reg) begin
                        dup_reg <= 1'b1;
                    end
                    if (!ra_valid_reg[idx_reg] && !slot_found_reg) begin
                        slot_found_reg <= 1'b1;
                        slot_reg       <= idx_reg;
                    end
                    idx_reg <= idx_reg + 1'b1;
                    if (last_idx) begin
                        state_reg <= ST_DSTOR;
                    end
                end

                ST_DSTOR: begin
                    if (!dup_reg) begin
                        if (!slot_found_reg) begin
                            dropped_reg <= 1'b1;
                        end else begin
                            ra_valid_reg[slot_reg] <= 1'b1;
                            ra_reg[slot_reg].seq   <= st_seq_reg;
                            ra_reg[slot_reg].len   <= st_len_reg;
                        end
                    end
                    idx_reg   <= '0;
                    state_reg <= ST_DDLV;
                end

                // deliver in-order entries, lowest index first
                ST_DDLV: begin
                    if (ra_valid_reg[idx_reg] && ra_reg[idx_reg].seq == recv_next_reg) begin
                        if (can_emit) begin
                            m_valid_reg           <= 1'b1;
                            m_last_reg            <= 1'b0;
                            m_kind_reg            <= tcpwc_pkg::KIND_DELIVER;
                            m_seq_reg             <= ra_reg[idx_reg].seq;
                            m_ack_reg             <= recv_next_reg
                                                   + {22'd0, ra_reg[idx_reg].len};
                            m_len_reg             <= ra_reg[idx_reg].len;
                            m_cs_reg              <= close_state_reg;
                            m_closed_reg          <= finished_reg;
                            m_drop_reg            <= dropped_reg;
                            ra_valid_reg[idx_reg] <= 1'b0;
                            recv_next_reg         <= recv_next_reg
                                                   + {22'd0, ra_reg[idx_reg].len};
                            idx_reg               <= '0;
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                        if (last_idx) begin
                            pend_seq_reg <= send_next_reg;
                            state_reg    <= ST_LAST;
                        end
                    end
                end

                // final result of the item
                ST_LAST: begin
                    if (can_emit) begin
                        m_valid_reg  <= 1'b1;
                        m_last_reg   <= 1'b1;
                        m_kind_reg   <= pend_kind_reg;
                        m_seq_reg    <= pend_seq_reg;
                        m_ack_reg    <= recv_next_reg;
                        m_len_reg    <= pend_len_reg;
                        m_cs_reg     <= close_state_reg;
                        m_closed_reg <= finished_reg;
                        m_drop_reg   <= dropped_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_drop_reg, m_closed_reg, m_cs_reg,
                       m_len_reg, m_ack_reg, m_seq_reg};

    // a finished connection stays finished
    assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |=> finished_reg)
        else $error("finished flag cleared");

    // no new item while one is in work
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("ready right after accept");

    // a delivery is never the final result of an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == tcpwc_pkg::KIND_DELIVER) |-> !m_last_reg)
        else $error("delivery marked last");

    // retiring an entry moves the unacknowledged edge to that entry's end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RCHK && best_found_reg && end_off <= ack_off)
        |=> (send_unacked_reg == $past(fl_end)))
        else $error("retire did not advance send_unacked");

endmodule

@@ verif/tcp_window_and_close_engine_checker.sv @@
// Checker for the TCP window and close engine: predicts results and compares them.
`timescale 1ns / 1ps
module tcp_window_and_close_engine_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic [2:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          n_errors,
    output int          n_pending,
    output logic [31:0] cur_send_next,
    output logic [31:0] cur_send_unacked,
    output logic [31:0] cur_recv_next
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [9:0]  len;
        logic [2:0]  cs;
        logic        closed;
        logic        dropped;
        logic        last;
    } segment_result_t;

    segment_result_t due_q[$];
    segment_result_t item_q[$];

    // connection state mirror
    logic [11:0] win;
    logic [31:0] snd_nxt, snd_una, rcv_nxt;
    logic [2:0]  close_st;
    logic        conn_done;
    logic        fl_v[tcpwc_pkg::TABLE_DEPTH];
    logic [31:0] fl_s[tcpwc_pkg::TABLE_DEPTH];
    logic [9:0]  fl_l[tcpwc_pkg::TABLE_DEPTH];
    logic        ra_v[tcpwc_pkg::TABLE_DEPTH];
    logic [31:0] ra_s[tcpwc_pkg::TABLE_DEPTH];
    logic [9:0]  ra_l[tcpwc_pkg::TABLE_DEPTH];

    assign n_pending        = due_q.size();
    assign cur_send_next    = snd_nxt;
    assign cur_send_unacked = snd_una;
    assign cur_recv_next    = rcv_nxt;

    initial n_errors = 0;

    function automatic void post(logic [2:0] kind, logic [31:0] sq, logic [31:0] ak,
                                 logic [9:0] ln);
        segment_result_t r;
        r.kind = kind; r.seq = sq; r.ack = ak; r.len = ln;
        r.cs = '0; r.closed = 1'b0; r.dropped = 1'b0; r.last = 1'b0;
        item_q.insert(item_q.size(), r);
    endfunction

    // retire in-flight entries covered by an ACK, lowest offset first
    function automatic void retire_flight(logic [31:0] ak);
        int best;
        logic [31:0] boff, off, endv;
        if ((ak - snd_una) > (snd_nxt - snd_una)) return;
        for (int it = 0; it < tcpwc_pkg::TABLE_DEPTH; it++) begin
            best = -1;
            boff = '0;
            for (int i = 0; i < tcpwc_pkg::TABLE_DEPTH; i++) begin
                off = fl_s[i] - snd_una;
                if (fl_v[i] && (best < 0 || off < boff)) begin
                    best = i;
                    boff = off;
                end
            end
            if (best < 0) break;
            endv = fl_s[best] + 32'(fl_l[best]);
            if ((endv - snd_una) > (ak - snd_una)) break;
            snd_una = endv;
            fl_v[best] = 1'b0;
        end
    endfunction

    // receive window check, trim, store and in-order delivery; returns drop flag
    function automatic logic reassemble(logic [31:0] sq, logic [9:0] ln);
        logic [31:0] dif, st_s;
        logic [9:0]  st_l;
        int d, n, slot, hit;
        logic dup, drop;
        drop = 1'b0;
        dif = sq - rcv_nxt;
        d = $signed(dif);
        n = ln;
        if (!(d >= tcpwc_pkg::RECV_WINDOW || d + n <= 0)) begin
            if (d < 0) begin
                st_s = rcv_nxt;
                st_l = 10'(d + n);
            end else begin
                st_s = sq;
                st_l = (d + n <= tcpwc_pkg::RECV_WINDOW) ? ln
                     : 10'(tcpwc_pkg::RECV_WINDOW - d);
            end
            dup = 1'b0;
            slot = -1;
            for (int i = 0; i < tcpwc_pkg::TABLE_DEPTH; i++) begin
                if (ra_v[i] && ra_s[i] == st_s) dup = 1'b1;
                if (!ra_v[i] && slot < 0) slot = i;
            end
            if (!dup) begin
                if (slot < 0) begin
                    drop = 1'b1;
                end else begin
                    ra_v[slot] = 1'b1;
                    ra_s[slot] = st_s;
                    ra_l[slot] = st_l;
                end
            end
            for (int it = 0; it < tcpwc_pkg::TABLE_DEPTH; it++) begin
                hit = -1;
                for (int i = 0; i < tcpwc_pkg::TABLE_DEPTH; i++)
                    if (ra_v[i] && ra_s[i] == rcv_nxt && hit < 0) hit = i;
                if (hit < 0) break;
                ra_v[hit] = 1'b0;
                rcv_nxt = rcv_nxt + 32'(ra_l[hit]);
                post(tcpwc_pkg::KIND_DELIVER, ra_s[hit], rcv_nxt, ra_l[hit]);
            end
        end
        post(tcpwc_pkg::KIND_ACK, snd_nxt, rcv_nxt, '0);
        return drop;
    endfunction

    // work out all results of one accepted request
    function automatic void predict(logic [1:0] fn, logic [31:0] sq, logic [31:0] ak,
                                    logic [9:0] ln, logic sfin, logic sack,
                                    logic [15:0] avail);
        logic [31:0] inflight, freew, n;
        logic drop;
        int slot;
        drop = 1'b0;
        item_q.delete();
        if (!conn_done && fn == tcpwc_pkg::FUNC_SEND) begin
            inflight = snd_nxt - snd_una;
            freew = (inflight >= 32'(win)) ? '0 : 32'(win) - inflight;
            n = 32'(avail);
            if (n > tcpwc_pkg::MAX_PAYLOAD) n = tcpwc_pkg::MAX_PAYLOAD;
            if (n > freew) n = freew;
            if (n > 0) begin
                slot = -1;
                for (int i = 0; i < tcpwc_pkg::TABLE_DEPTH; i++)
                    if (!fl_v[i] && slot < 0) slot = i;
                if (slot < 0) begin
                    drop = 1'b1;
                end else begin
                    fl_v[slot] = 1'b1;
                    fl_s[slot] = snd_nxt;
                    fl_l[slot] = n[9:0];
                    post(tcpwc_pkg::KIND_DATA, snd_nxt, rcv_nxt, n[9:0]);
                    snd_nxt = snd_nxt + n;
                end
            end
        end else if (!conn_done && fn == tcpwc_pkg::FUNC_SEG) begin
            if (sfin) begin
                if (close_st == tcpwc_pkg::CS_FIN_WAIT_1) begin
                    post(tcpwc_pkg::KIND_ACK, snd_nxt, rcv_nxt, '0);
                    close_st = tcpwc_pkg::CS_CLOSING;
                end else if (close_st == tcpwc_pkg::CS_FIN_WAIT_2) begin
                    post(tcpwc_pkg::KIND_ACK, snd_nxt, rcv_nxt, '0);
                    conn_done = 1'b1;
                end else if (close_st == tcpwc_pkg::CS_ESTABLISHED) begin
                    post(tcpwc_pkg::KIND_ACK, snd_nxt, rcv_nxt, '0);
                    close_st = tcpwc_pkg::CS_CLOSE_WAIT;
                end
            end else if (sack) begin
                retire_flight(ak);
                if (close_st == tcpwc_pkg::CS_FIN_WAIT_1)
                    close_st = tcpwc_pkg::CS_FIN_WAIT_2;
                else if (close_st == tcpwc_pkg::CS_CLOSING
                         || close_st == tcpwc_pkg::CS_LAST_ACK)
                    conn_done = 1'b1;
            end else if (ln > 0) begin
                drop = reassemble(sq, ln);
            end
        end else if (!conn_done && fn == tcpwc_pkg::FUNC_CLOSE) begin
            if (close_st == tcpwc_pkg::CS_ESTABLISHED) begin
                post(tcpwc_pkg::KIND_FIN, snd_nxt, rcv_nxt, '0);
                close_st = tcpwc_pkg::CS_FIN_WAIT_1;
            end else if (close_st == tcpwc_pkg::CS_CLOSE_WAIT) begin
                post(tcpwc_pkg::KIND_FIN, snd_nxt, rcv_nxt, '0);
                close_st = tcpwc_pkg::CS_LAST_ACK;
            end
        end
        if (item_q.size() == 0) post(tcpwc_pkg::KIND_STATUS, snd_nxt, rcv_nxt, '0);
        foreach (item_q[k]) begin
            item_q[k].cs      = close_st;
            item_q[k].closed  = conn_done;
            item_q[k].dropped = drop;
            item_q[k].last    = (k == item_q.size() - 1);
            due_q.insert(due_q.size(), item_q[k]);
        end
    endfunction

    // compare, then predict, then register writes, all on the rising edge
    always @(posedge aclk) begin
        segment_result_t e, a;
        if (!aresetn) begin
            win = 12'd3072;
            snd_nxt = 32'd1;
            snd_una = 32'd1;
            rcv_nxt = 32'd1;
            close_st = tcpwc_pkg::CS_ESTABLISHED;
            conn_done = 1'b0;
            for (int i = 0; i < tcpwc_pkg::TABLE_DEPTH; i++) begin
                fl_v[i] = 1'b0; fl_s[i] = '0; fl_l[i] = '0;
                ra_v[i] = 1'b0; ra_s[i] = '0; ra_l[i] = '0;
            end
            due_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                a.kind = m_tuser;        a.seq = m_tdata[31:0];
                a.ack = m_tdata[63:32];  a.len = m_tdata[73:64];
                a.cs = m_tdata[76:74];   a.closed = m_tdata[77];
                a.dropped = m_tdata[78]; a.last = m_tlast;
                if (due_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result transfer: kind %0d seq %h ack %h len %0d",
                                 a.kind, a.seq, a.ack, a.len);
                end else begin
                    e = due_q.pop_front();
                    if (a != e) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $display("mismatch: expected kind %0d seq %h ack %h len %0d cs %0d cl %b dr %b last %b",
                                     e.kind, e.seq, e.ack, e.len, e.cs, e.closed,
                                     e.dropped, e.last);
                            $display("          got      kind %0d seq %h ack %h len %0d cs %0d cl %b dr %b last %b",
                                     a.kind, a.seq, a.ack, a.len, a.cs, a.closed,
                                     a.dropped, a.last);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[73:64],
                        s_tdata[74], s_tdata[75], s_tdata[91:76]);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tcpwc_pkg::REG_SEND_WINDOW: win = cfg_data[11:0];
                    tcpwc_pkg::REG_LOCAL_SEQ: begin
                        snd_nxt = cfg_data;
                        snd_una = cfg_data;
                    end
                    tcpwc_pkg::REG_REMOTE_SEQ: rcv_nxt = cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ verif/tcp_window_and_close_engine_core_tb.sv @@
// Testbench top for the TCP window and close engine: stimulus and verdict.
`timescale 1ns / 1ps
module tcp_window_and_close_engine_core_tb;

    localparam int DRAIN_CYCLES = 120;
    // selector value with no request behind it
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int          n_errors, n_pending;
    logic [31:0] snd_nxt, snd_una, rcv_nxt;
    int          tx_idle = 35;
    int          rx_idle = 55;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_cnt = 0;

    tcp_window_and_close_engine_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    tcp_window_and_close_engine_checker u_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .n_errors(n_errors), .n_pending(n_pending),
        .cur_send_next(snd_nxt), .cur_send_unacked(snd_una), .cur_recv_next(rcv_nxt)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result sink: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt  <= 400;
            m_tready  <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial begin
        #(8 * 800_000);
        $display("DONE: errors detected");
        $finish;
    end

    // one request transfer; returns at the following falling edge
    task automatic put_req(input logic [1:0] fn, input logic [31:0] sq, input logic [31:0] ak,
                           input logic [9:0] ln, input logic sfin, input logic sack,
                           input logic [15:0] avail);
        do @(posedge aclk); while ($urandom_range(99) < tx_idle);
        s_tdata  <= {4'd0, avail, sack, sfin, ln, ak, sq};
        s_tuser  <= fn;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        s_tvalid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        while (n_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic app_send(input logic [15:0] avail);
        put_req(tcpwc_pkg::FUNC_SEND, $urandom, $urandom, 10'($urandom), 1'b0, 1'b0, avail);
    endtask

    task automatic net_ack(input logic [31:0] ak);
        put_req(tcpwc_pkg::FUNC_SEG, $urandom, ak, 10'($urandom_range(536)), 1'b0, 1'b1,
                16'($urandom));
    endtask

    task automatic net_data(input logic [31:0] sq, input logic [9:0] ln);
        put_req(tcpwc_pkg::FUNC_SEG, sq, $urandom, ln, 1'b0, 1'b0, 16'($urandom));
    endtask

    task automatic close_req();
        put_req(tcpwc_pkg::FUNC_CLOSE, '0, '0, '0, 1'b0, 1'b0, '0);
    endtask

    task automatic net_fin();
        put_req(tcpwc_pkg::FUNC_SEG, '0, '0, '0, 1'b1, 1'b0, '0);
    endtask

    // mostly well-formed traffic around the current sequence numbers
    task automatic random_req();
        int pick;
        logic [31:0] sq;
        logic [9:0]  ln;
        pick = $urandom_range(99);
        if (pick < 28) begin
            case ($urandom_range(3))
                0: app_send(16'($urandom_range(64)));
                1: app_send(16'hFFFF);
                default: app_send(16'($urandom));
            endcase
        end else if (pick < 50) begin
            if ($urandom_range(9) < 8) net_ack(snd_una + $urandom_range(snd_nxt - snd_una));
            else net_ack($urandom);
        end else if (pick < 92) begin
            ln = 10'(64 * $urandom_range(1, 8));
            case ($urandom_range(9))
                0, 1, 2, 3: sq = rcv_nxt;
                4, 5, 6:    sq = rcv_nxt + 64 * $urandom_range(1, 10);
                7:          sq = rcv_nxt - 64 * $urandom_range(1, 6);
                8:          sq = rcv_nxt + 64 * $urandom_range(40, 52);
                default:    sq = rcv_nxt + 3072 + $urandom_range(4000);
            endcase
            net_data(sq, ln);
        end else begin
            case ($urandom_range(3))
                0: put_req(FUNC_UNUSED, $urandom, $urandom, 10'($urandom), 1'($urandom),
                           1'($urandom), 16'($urandom));
                1: put_req(tcpwc_pkg::FUNC_SEG, $urandom, $urandom, '0, 1'b0, 1'b0,
                           16'($urandom));
                2: net_data($urandom, 10'($urandom));
                default: net_data(rcv_nxt + $urandom_range(200), 10'($urandom_range(1, 1023)));
            endcase
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero window first: a send yields only a status result
        write_reg(tcpwc_pkg::REG_SEND_WINDOW, 32'd0);
        write_reg(tcpwc_pkg::REG_LOCAL_SEQ, 32'd0);
        write_reg(tcpwc_pkg::REG_REMOTE_SEQ, 32'd0);
        app_send(16'd100);
        settle();
        write_reg(tcpwc_pkg::REG_SEND_WINDOW, 32'd3072);
        write_reg(tcpwc_pkg::REG_LOCAL_SEQ, 32'hFFFF_FF80);
        write_reg(tcpwc_pkg::REG_REMOTE_SEQ, 32'hFFFF_FFC0);

        // sends: zero, capped, then fill the in-flight table
        app_send(16'd0);
        app_send(16'hFFFF);
        for (int i = 0; i < 8; i++) app_send(16'd1);
        net_ack(snd_una - 1);
        net_ack(snd_una + 536);
        net_ack(snd_nxt);

        // reassembly: in order, chained, window edges, below window
        net_data(rcv_nxt, 10'd64);
        net_data(rcv_nxt + 128, 10'd64);
        net_data(rcv_nxt + 64, 10'd64);
        net_data(rcv_nxt + 3072, 10'd10);
        net_data(rcv_nxt - 100, 10'd100);
        net_data(rcv_nxt - 50, 10'd100);
        net_data(rcv_nxt + 3000, 10'd200);
        net_data(rcv_nxt + 3000, 10'd536);
        put_req(FUNC_UNUSED, '1, '1, '1, 1'b1, 1'b1, '1);
        put_req(tcpwc_pkg::FUNC_SEG, '0, '0, '0, 1'b0, 1'b0, '0);

        // fill the store until a segment drops, then shift the receive point onto
        // the lowest entry so a duplicate start releases the whole chain
        for (int m = 1; m <= 8; m++) net_data(rcv_nxt + 64 * m, 10'd64);
        settle();
        write_reg(tcpwc_pkg::REG_REMOTE_SEQ, rcv_nxt + 64);
        net_data(rcv_nxt, 10'd64);
        net_data(rcv_nxt, 10'd1023);

        // random traffic with sender gaps and a long sink hold-off
        for (int i = 0; i < 30; i++) begin
            if (i == 10) hold_go = 1'b1;
            random_req();
        end
        net_ack(snd_nxt);
        settle();
        tx_idle = 55;
        rx_idle = 35;
        write_reg(tcpwc_pkg::REG_SEND_WINDOW, 32'd600);
        write_reg(tcpwc_pkg::REG_LOCAL_SEQ, 32'hFFFF_FFFF);
        write_reg(tcpwc_pkg::REG_REMOTE_SEQ, rcv_nxt);
        for (int i = 0; i < 30; i++) random_req();
        net_ack(snd_nxt);
        settle();
        tx_idle = 0;
        rx_idle = 0;
        write_reg(tcpwc_pkg::REG_SEND_WINDOW, 32'd3072);
        write_reg(tcpwc_pkg::REG_LOCAL_SEQ, 32'h7FFF_FFFF);
        write_reg(tcpwc_pkg::REG_REMOTE_SEQ, rcv_nxt);
        for (int i = 0; i < 30; i++) random_req();

        // one of the three close paths, then requests after the connection ends
        case ($urandom_range(2))
            0: begin
                close_req();
                put_req(tcpwc_pkg::FUNC_SEG, rcv_nxt, snd_nxt, 10'd64, 1'b1, 1'b1, '0);
                app_send(16'd50);
                net_ack(snd_nxt);
            end
            1: begin
                close_req();
                net_ack(snd_nxt);
                close_req();
                net_data(rcv_nxt, 10'd128);
                net_fin();
            end
            default: begin
                net_fin();
                net_fin();
                close_req();
                net_ack(snd_nxt);
            end
        endcase
        app_send(16'd10);
        net_data(rcv_nxt, 10'd64);
        close_req();

        settle();
        if (n_errors == 0 && n_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
